>>> rtl/amc_pkg.sv
// Shared types and constants for the alpha morphological closing block.
package amc_pkg;

   localparam int ALPHA_W = 8;
   localparam int ROW_W = 17;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_PTR_W = 4;

   localparam logic [11:0] WIDTH_RESET = 12'd640;
   localparam logic [15:0] HEIGHT_RESET = 16'd480;
   localparam logic [2:0] RADIUS_RESET = 3'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_WINDOW_RADIUS
   } amc_csr_type;

   // One step travelling down the window pipeline.
   typedef struct packed {
      logic valid;
      logic live;
      logic first;
   } amc_step_type;

endpackage

>>> rtl/amc_window_stage.sv
// One clipped square-window maximum stage built on a ring of line-store banks.
module amc_window_stage
   import amc_pkg::*;
#(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_RADIUS = 4,
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int RW = $clog2(MAX_RADIUS + 1),
   localparam int HLW = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  amc_step_type        in_step,
   input  logic [ALPHA_W-1:0]  in_value,
   input  logic [WW-1:0]       width_eff,
   input  logic [15:0]         height_eff,
   input  logic [RW-1:0]       radius_eff,
   input  logic [HLW-1:0]      half_lag,
   output amc_step_type        out_step,
   output logic [ALPHA_W-1:0]  out_value,
   output logic [ROW_W-1:0]    out_row,
   output logic [CW-1:0]       out_col
);

   localparam int NB = 2 * MAX_RADIUS + 1;
   localparam int BW = $clog2(NB);
   localparam int DW = BW + 1;
   localparam int XW = WW + 2;

   // Maximum over the kept entries, resolved one bit at a time from the top.
   function automatic logic [ALPHA_W-1:0] masked_max(input logic [NB-1:0][ALPHA_W-1:0] vals,
                                                     input logic [NB-1:0] keep);
      logic [NB-1:0] cand;
      logic [ALPHA_W-1:0] res;
      logic any;
      cand = keep;
      res = '0;
      for (int i = ALPHA_W - 1; i >= 0; i--) begin
         any = 1'b0;
         for (int b = 0; b < NB; b++) begin
            if (cand[b] && vals[b][i]) begin
               any = 1'b1;
            end
         end
         res[i] = any;
         if (any) begin
            for (int b = 0; b < NB; b++) begin
               if (!vals[b][i]) begin
                  cand[b] = 1'b0;
               end
            end
         end
      end
      return res;
   endfunction

   // Input position and center position counters.
   logic [ROW_W-1:0] row_ff, row_in, cur_row;
   logic [CW-1:0] col_ff, col_in, cur_col;
   logic [BW-1:0] bank_ff, bank_in, cur_bank;
   logic [HLW-1:0] p_ff, p_in, p_cur;
   logic [ROW_W-1:0] crow_ff, crow_in, c_row;
   logic [CW-1:0] ccol_ff, ccol_in, c_col;
   logic started_ff, started_in, started_cur;
   logic step_en, col_wrap, c_wrap, present, olive, ofirst;

   always_comb begin
      step_en = in_step.valid && in_step.live;
      cur_row = in_step.first ? '0 : row_ff;
      cur_col = in_step.first ? '0 : col_ff;
      cur_bank = in_step.first ? '0 : bank_ff;
      p_cur = in_step.first ? '0 : p_ff;
      started_cur = in_step.first ? 1'b0 : started_ff;
      col_wrap = (WW'(cur_col) + WW'(1)) == width_eff;
      present = cur_row < ROW_W'(height_eff);
      olive = p_cur >= half_lag;
      // Only the first centered step of a frame restarts the center counters.
      ofirst = olive && !started_cur;
      c_row = ofirst ? '0 : crow_ff;
      c_col = ofirst ? '0 : ccol_ff;
      c_wrap = (WW'(c_col) + WW'(1)) == width_eff;

      row_in = row_ff;
      col_in = col_ff;
      bank_in = bank_ff;
      p_in = p_ff;
      started_in = started_ff;
      crow_in = crow_ff;
      ccol_in = ccol_ff;
      if (step_en) begin
         p_in = olive ? p_cur : p_cur + HLW'(1);
         started_in = started_cur || olive;
         if (col_wrap) begin
            col_in = '0;
            row_in = cur_row + ROW_W'(1);
            bank_in = (cur_bank == BW'(NB - 1)) ? '0 : cur_bank + BW'(1);
         end else begin
            col_in = cur_col + CW'(1);
            row_in = cur_row;
            bank_in = cur_bank;
         end
         if (olive) begin
            if (c_wrap) begin
               ccol_in = '0;
               crow_in = c_row + ROW_W'(1);
            end else begin
               ccol_in = c_col + CW'(1);
               crow_in = c_row;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         bank_ff <= '0;
         p_ff <= '0;
         started_ff <= 1'b0;
         crow_ff <= '0;
         ccol_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         bank_ff <= bank_in;
         p_ff <= p_in;
         started_ff <= started_in;
         crow_ff <= crow_in;
         ccol_ff <= ccol_in;
      end
   end

   // Line-store banks: one row each, the current row is written while all are read.
   logic [NB-1:0][ALPHA_W-1:0] rd_vals;

   for (genvar b = 0; b < NB; b++) begin : g_bank
      logic [ALPHA_W-1:0] mem [MAX_WIDTH];
      logic [ALPHA_W-1:0] rd_ff;
      always_ff @(posedge clock) begin
         if (step_en && present && (cur_bank == BW'(b))) begin
            mem[cur_col] <= in_value;
         end
         if (step_en) begin
            rd_ff <= mem[cur_col];
         end
      end
      assign rd_vals[b] = rd_ff;
   end

   // First pipeline register.
   logic s1_valid_ff, s1_live_ff, s1_olive_ff, s1_ofirst_ff;
   logic [ROW_W-1:0] s1_row_ff, s1_crow_ff;
   logic [BW-1:0] s1_bank_ff;
   logic [CW-1:0] s1_ccol_ff;
   logic [ALPHA_W-1:0] s1_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_live_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_step.valid;
         s1_live_ff <= in_step.live;
      end
      s1_olive_ff <= step_en && olive;
      s1_ofirst_ff <= ofirst;
      s1_row_ff <= cur_row;
      s1_bank_ff <= cur_bank;
      s1_value_ff <= in_value;
      s1_crow_ff <= c_row;
      s1_ccol_ff <= c_col;
   end

   // Vertical maximum over the rows of the window that lie inside the frame.
   logic [NB-1:0][ALPHA_W-1:0] v_vals;
   logic [NB-1:0] v_keep;
   logic [DW-1:0] row_back;
   logic [ALPHA_W-1:0] vmax;

   always_comb begin
      row_back = '0;
      for (int b = 0; b < NB; b++) begin
         row_back = DW'(s1_bank_ff) + DW'(NB) - DW'(b);
         if (row_back >= DW'(NB)) begin
            row_back = row_back - DW'(NB);
         end
         v_vals[b] = (row_back == '0) ? s1_value_ff : rd_vals[b];
         v_keep[b] = (ROW_W'(row_back) <= ROW_W'(radius_eff) + ROW_W'(radius_eff))
                     && (ROW_W'(row_back) <= s1_row_ff)
                     && (s1_row_ff < ROW_W'(height_eff) + ROW_W'(row_back));
      end
      vmax = masked_max(v_vals, v_keep);
   end

   // Column results of the current row span, newest at index 0.
   logic [NB-1:0][ALPHA_W-1:0] hreg_ff;
   logic s2_valid_ff, s2_olive_ff, s2_ofirst_ff;
   logic [ROW_W-1:0] s2_crow_ff;
   logic [CW-1:0] s2_ccol_ff;

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_live_ff) begin
         hreg_ff <= {hreg_ff[NB-2:0], vmax};
      end
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s2_olive_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
         s2_olive_ff <= s1_olive_ff;
      end
      s2_ofirst_ff <= s1_ofirst_ff;
      s2_crow_ff <= s1_crow_ff;
      s2_ccol_ff <= s1_ccol_ff;
   end

   // Horizontal maximum over the columns of the center's own row.
   logic [NB-1:0] h_keep;
   logic [XW-1:0] c_reach;
   logic [ALPHA_W-1:0] hmax;

   always_comb begin
      c_reach = XW'(s2_ccol_ff) + XW'(radius_eff);
      for (int k = 0; k < NB; k++) begin
         h_keep[k] = (XW'(k) <= XW'(radius_eff) + XW'(radius_eff))
                     && (XW'(k) <= c_reach)
                     && (c_reach < XW'(width_eff) + XW'(k));
      end
      hmax = masked_max(hreg_ff, h_keep);
   end

   amc_step_type out_step_ff;
   logic [ALPHA_W-1:0] out_value_ff;
   logic [ROW_W-1:0] out_row_ff;
   logic [CW-1:0] out_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_step_ff <= '0;
      end else begin
         out_step_ff.valid <= s2_valid_ff;
         out_step_ff.live <= s2_olive_ff;
         out_step_ff.first <= s2_ofirst_ff;
      end
      out_value_ff <= hmax;
      out_row_ff <= s2_crow_ff;
      out_col_ff <= s2_ccol_ff;
   end

   assign out_step = out_step_ff;
   assign out_value = out_value_ff;
   assign out_row = out_row_ff;
   assign out_col = out_col_ff;

endmodule

>>> rtl/alpha_morphological_close_top.sv
// Top level of the streaming alpha morphological closing block.
//
// The block takes the alpha byte of one pixel per item in raster order and
// returns its grayscale closing: a dilation (maximum over a square window of
// side 2*radius+1) followed by an erosion (minimum over the same window) of
// the dilated image, with the window clipped at the frame edges. A radius of 0
// passes the alpha through. Result m of a frame leaves on the item at frame
// position m + 2*radius*W + 2*radius, so after the last pixel the source sends
// that many flush items to drain the frame; the result flagged end_of_frame is
// the last one, and the next pixel opens a new frame. A flush sent before all
// pixels of the frame have arrived is taken and ignored, and a pixel sent while
// the frame is still draining counts as a flush. The block accepts one item
// every clock: each stage makes one line-store access per item, with one bank
// per window row so all rows are read in parallel. A 16-entry result queue
// decouples the two sides; the input also stalls when that queue together
// with the items in flight would overfill. Configuration registers are
// written while the block is idle; a write restarts the frame, and the input
// stays blocked afterwards while the derived frame sizes settle.
module alpha_morphological_close_top
   import amc_pkg::*;
#(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_RADIUS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [ALPHA_W-1:0]     req_alpha_in,
   input  logic                   req_flush,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [ALPHA_W-1:0]     rsp_alpha_out,
   output logic                   rsp_end_of_frame,
   input  logic                   csr_write_enable,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_RADIUS + 1);
   localparam int HLW = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
   localparam int TW = WW + 16;
   localparam int VW = WW + 17;
   localparam int UW = FIFO_PTR_W + 2;

   // Configuration registers.
   logic [11:0] image_width_ff;
   logic [15:0] image_height_ff;
   logic [2:0] window_radius_ff;
   logic restart;
   logic [1:0] settle_ff;

   always_comb begin
      restart = 1'b0;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT, CSR_WINDOW_RADIUS: begin
               restart = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
         window_radius_ff <= RADIUS_RESET;
         settle_ff <= 2'd3;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_IMAGE_WIDTH: begin
                  image_width_ff <= csr_wdata[11:0];
               end
               CSR_IMAGE_HEIGHT: begin
                  image_height_ff <= csr_wdata;
               end
               CSR_WINDOW_RADIUS: begin
                  window_radius_ff <= csr_wdata[2:0];
               end
               default: begin
               end
            endcase
         end
         if (restart) begin
            settle_ff <= 2'd3;
         end else if (settle_ff != 2'd0) begin
            settle_ff <= settle_ff - 2'd1;
         end
      end
   end

   // Out-of-range register values are clamped to their working range.
   logic [WW-1:0] w_eff;
   logic [15:0] h_eff;
   logic [RW-1:0] r_eff;

   always_comb begin
      if (image_width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(image_width_ff);
      end
      h_eff = (image_height_ff == '0) ? 16'd1 : image_height_ff;
      r_eff = (32'(window_radius_ff) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(window_radius_ff);
   end

   // Derived frame sizes, registered; stable by the time the input opens.
   logic [HLW-1:0] half_lag_ff;
   logic [TW-1:0] total_ff;
   logic [VW-1:0] end_v_ff;

   always_ff @(posedge clock) begin
      half_lag_ff <= HLW'(HLW'(r_eff) * HLW'(w_eff) + HLW'(r_eff));
      total_ff <= TW'(TW'(w_eff) * TW'(h_eff));
      end_v_ff <= VW'(total_ff) + VW'(half_lag_ff) + VW'(half_lag_ff) - VW'(1);
   end

   // Frame position of the next item and dispatch into the pipeline.
   logic [VW-1:0] v_ff;
   logic accept, dispatch;
   amc_step_type s0_step_ff;
   logic [ALPHA_W-1:0] s0_alpha_ff;

   assign accept = req_valid && req_ready;
   assign dispatch = accept && !((v_ff < VW'(total_ff)) && req_flush);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         s0_step_ff <= '0;
      end else begin
         if (restart) begin
            v_ff <= '0;
         end else if (dispatch) begin
            v_ff <= (v_ff == end_v_ff) ? '0 : v_ff + VW'(1);
         end
         s0_step_ff.valid <= dispatch;
         s0_step_ff.live <= 1'b1;
         s0_step_ff.first <= v_ff == '0;
      end
      s0_alpha_ff <= req_alpha_in;
   end

   // Dilation stage, then erosion done as a maximum on inverted values.
   amc_step_type dil_step, ero_step;
   logic [ALPHA_W-1:0] dil_value, ero_value;
   logic [ROW_W-1:0] ero_row;
   logic [CW-1:0] ero_col;

   amc_window_stage #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_dilate (
      .clock      (clock),
      .reset      (reset),
      .in_step    (s0_step_ff),
      .in_value   (s0_alpha_ff),
      .width_eff  (w_eff),
      .height_eff (h_eff),
      .radius_eff (r_eff),
      .half_lag   (half_lag_ff),
      .out_step   (dil_step),
      .out_value  (dil_value),
      .out_row    (),
      .out_col    ()
   );

   amc_window_stage #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_erode (
      .clock      (clock),
      .reset      (reset),
      .in_step    (dil_step),
      .in_value   (~dil_value),
      .width_eff  (w_eff),
      .height_eff (h_eff),
      .radius_eff (r_eff),
      .half_lag   (half_lag_ff),
      .out_step   (ero_step),
      .out_value  (ero_value),
      .out_row    (ero_row),
      .out_col    (ero_col)
   );

   // Items in the pipeline, each of which may still produce one result.
   logic [3:0] inflight_ff;
   logic push, pop, last_pixel;

   assign push = ero_step.valid && ero_step.live;
   assign last_pixel = (ero_row == ROW_W'(h_eff) - ROW_W'(1))
                       && ((WW'(ero_col) + WW'(1)) == w_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_ff + 4'(dispatch) - 4'(ero_step.valid);
      end
   end

   // Result queue.
   logic [ALPHA_W-1:0] fifo_alpha_ff [FIFO_DEPTH];
   logic fifo_eof_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] head_ff, tail_ff;
   logic [FIFO_PTR_W:0] count_ff;
   logic [UW-1:0] used;

   assign rsp_valid = count_ff != '0;
   assign pop = rsp_valid && rsp_ready;
   assign rsp_alpha_out = fifo_alpha_ff[head_ff];
   assign rsp_end_of_frame = fifo_eof_ff[head_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_alpha_ff[tail_ff] <= ~ero_value;
         fifo_eof_ff[tail_ff] <= last_pixel;
      end
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            tail_ff <= tail_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            head_ff <= head_ff + FIFO_PTR_W'(1);
         end
         count_ff <= count_ff + (FIFO_PTR_W + 1)'(push) - (FIFO_PTR_W + 1)'(pop);
      end
   end

   assign used = UW'(count_ff) + UW'(inflight_ff);
   assign req_ready = (settle_ff == 2'd0) && (used < UW'(FIFO_DEPTH));

endmodule
